// ===== rtl/ksm_pkg.sv =====
// Shared types and constants of the keyframe step sampler.
// Used by the divider, the top level and the port checker; depends on nothing.
package ksm_pkg;

   // Default depth of the keyframe table.
   localparam int MAX_KEYS_DEFAULT = 16;

   // Field widths of the stream words.
   localparam int INDEX_W  = 4;
   localparam int POS_W    = 17;
   localparam int VAL_W    = 32;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 5;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   // Request tdata layout, lowest bit first.
   localparam int REQ_INDEX_LSB = 0;
   localparam int REQ_POS_LSB   = REQ_INDEX_LSB + INDEX_W;
   localparam int REQ_VAL_LSB   = REQ_POS_LSB + POS_W;
   localparam int REQ_TIME_LSB  = REQ_VAL_LSB + VAL_W;
   localparam int REQ_BITS      = REQ_TIME_LSB + TIME_W;
   localparam int REQ_TDATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // Response word: tdata is the value, tuser carries two flags.
   localparam int RSP_TDATA_W    = VAL_W;
   localparam int RSP_TUSER_W    = 2;
   localparam int RSP_USER_VALID = 0;
   localparam int RSP_USER_END   = 1;

   // Q1.16 one.
   localparam logic [POS_W-1:0] FRAC_ONE = POS_W'(65536);

   // Long division of {d, 16 zero bits} by the duration.
   localparam int FRAC_BITS = 16;
   localparam int DIV_STEPS = TIME_W + FRAC_BITS;

   // Request kinds carried in tuser.
   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // Register indexes of the configuration channel.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TIME  = 2'd0,
      CSR_DURATION    = 2'd1,
      CSR_LOOP_ENABLE = 2'd2,
      CSR_KEY_COUNT   = 2'd3
   } csr_index_type;

endpackage

// ===== rtl/ksm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the keyframe table; depends on nothing.
module ksm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ksm_frac_div.sv =====
// Bit-serial shift-subtract divider that forms the Q0.16 fraction of a span.
// Depends on ksm_pkg for widths and the step count.
module ksm_frac_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ksm_pkg::TIME_W-1:0]  dividend,
   input  logic [ksm_pkg::TIME_W-1:0]  divisor,
   output logic                        done,
   output logic [ksm_pkg::FRAC_BITS-1:0] quotient
);
   import ksm_pkg::*;

   localparam int NUM_W  = TIME_W + FRAC_BITS;
   localparam int STEP_W = $clog2(DIV_STEPS);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [TIME_W-1:0]    divisor_ff, divisor_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [TIME_W:0]      shifted;
   logic [TIME_W:0]      diff;
   logic                 take;

   // One restoring step: shift in the next numerator bit, subtract when it fits.
   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign take    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      active_in  = active_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      done_in    = 1'b0;
      if (start) begin
         active_in  = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         num_in     = {dividend, {FRAC_BITS{1'b0}}};
         divisor_in = divisor;
      end else if (active_ff) begin
         rem_in  = take ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[FRAC_BITS-2:0], take};
         step_in = step_ff + 1'b1;
         // The last step leaves the low quotient bits, which are the fraction.
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/keyframe_step_sampler_top.sv =====
// Keyframe step sampler top level: request decode, sequencer and result register.
// Depends on ksm_pkg, ksm_ram and ksm_frac_div.
//
// A write word stores one keyframe when its index lies below the key count. A sample
// word on the looping path first runs the shift-subtract divider, one quotient bit per
// step, and takes the fraction from it. The key walk then reads the table RAM, with
// ST_WALK_RD and ST_WALK_CMP for each key, until it meets a larger key or the last key
// in use, and ST_FINISH loads the result. Zero keys go straight to ST_FINISH; a clamped
// sample outside the span reads one entry in ST_END_RD and ST_END_CAP; a zero duration
// skips the divider. The request side is not ready while a sample is at work. A finished
// word waits in the output register and does not block the next request, but the next
// sample holds in ST_FINISH until that register has been read. The table needs no
// clearing pass after reset.
module keyframe_step_sampler_top #(
   parameter int MAX_KEYS = ksm_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index[3:0], key_position[20:4], key_value[52:21], sample_time[84:53]
   input  logic [ksm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation[0]
   input  logic [0:0]                      req_tuser,
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sampled_value[31:0]
   output logic [ksm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // result_valid[0], at_end[1]
   output logic [ksm_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ksm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ksm_pkg::CSR_W-1:0]       csr_data
);
   import ksm_pkg::*;

   localparam int AW    = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int ENT_W = POS_W + VAL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_END_RD,
      ST_END_CAP,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [TIME_W-1:0]  start_ff, duration_ff;
   logic               loop_ff;
   logic [COUNT_W-1:0] key_count_ff;

   // Sequencer and result registers.
   state_type          state_ff, state_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [POS_W-1:0]   frac_ff, frac_in;
   logic [VAL_W-1:0]   value_ff, value_in;
   logic               after_ff, after_in;
   logic               hit_valid_ff, hit_valid_in;
   logic               at_end_ff, at_end_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic               req_accept;
   op_type             req_op;
   logic [INDEX_W-1:0] req_index;
   logic [POS_W-1:0]   req_pos;
   logic [VAL_W-1:0]   req_val;
   logic [TIME_W-1:0]  req_time;
   logic [CNT_W-1:0]   key_cnt;
   logic [TIME_W-1:0]  span_end;
   logic               before_start, after_start, past_end;
   logic               ram_wr_en;
   logic [ENT_W-1:0]   ram_rd_data;
   logic [POS_W-1:0]   rd_pos;
   logic [VAL_W-1:0]   rd_val;
   logic               div_start, div_done;
   logic [TIME_W-1:0]  div_dividend;
   logic [FRAC_BITS-1:0] div_quot;

   // Request word fields.
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser[0]);
   assign req_index  = req_tdata[REQ_INDEX_LSB +: INDEX_W];
   assign req_pos    = req_tdata[REQ_POS_LSB +: POS_W];
   assign req_val    = req_tdata[REQ_VAL_LSB +: VAL_W];
   assign req_time   = req_tdata[REQ_TIME_LSB +: TIME_W];

   // Key count in use, saturated to the table depth.
   assign key_cnt = (32'(key_count_ff) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                        : CNT_W'(key_count_ff);

   // Position of the sample time against the animation span.
   assign span_end     = start_ff + duration_ff;
   assign before_start = req_time < start_ff;
   assign after_start  = req_time > start_ff;
   assign past_end     = req_time > span_end;
   assign div_dividend = after_start ? (req_time - start_ff) : (start_ff - req_time);

   // Keyframe table: position above value in one word.
   assign ram_wr_en = req_accept && (req_op == OP_WRITE) &&
                      (32'(req_index) < 32'(key_cnt));

   ksm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_index)),
      .wr_data ({req_pos, req_val}),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_pos = ram_rd_data[VAL_W +: POS_W];
   assign rd_val = ram_rd_data[VAL_W-1:0];

   // Divider for the span fraction.
   ksm_frac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (duration_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      frac_in       = frac_ff;
      value_in      = value_ff;
      after_in      = after_ff;
      hit_valid_in  = hit_valid_ff;
      at_end_in     = at_end_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == OP_SAMPLE)) begin
               hit_valid_in = 1'b1;
               at_end_in    = 1'b0;
               addr_in      = '0;
               value_in     = '0;
               after_in     = after_start;
               priority if (key_cnt == '0) begin
                  hit_valid_in = 1'b0;
                  state_in     = ST_FINISH;
               end else if (!loop_ff && before_start) begin
                  // Clamped before the span: first entry.
                  at_end_in = 1'b1;
                  state_in  = ST_END_RD;
               end else if (!loop_ff && past_end) begin
                  // Clamped after the span: last entry in use.
                  at_end_in = 1'b1;
                  addr_in   = AW'(key_cnt - 1'b1);
                  state_in  = ST_END_RD;
               end else if (duration_ff == '0) begin
                  frac_in  = FRAC_ONE;
                  state_in = ST_WALK_RD;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               frac_in  = after_ff ? {1'b0, div_quot} : (FRAC_ONE - {1'b0, div_quot});
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_CMP;
         end
         ST_WALK_CMP: begin
            // Entry 0 answers even when the fraction lies below its key.
            if ((addr_ff == '0) || (rd_pos <= frac_ff)) begin
               value_in = rd_val;
            end
            if ((rd_pos <= frac_ff) && ((32'(addr_ff) + 32'd1) < 32'(key_cnt))) begin
               addr_in  = addr_ff + 1'b1;
               state_in = ST_WALK_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_END_RD: begin
            state_in = ST_END_CAP;
         end
         ST_END_CAP: begin
            value_in = rd_val;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Load the output register once it is free.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = value_ff;
               rsp_tuser_in[RSP_USER_VALID] = hit_valid_ff;
               rsp_tuser_in[RSP_USER_END]   = at_end_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, configuration and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         start_ff      <= '0;
         duration_ff   <= '0;
         loop_ff       <= 1'b0;
         key_count_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_START_TIME:  start_ff     <= csr_data[TIME_W-1:0];
               CSR_DURATION:    duration_ff  <= csr_data[TIME_W-1:0];
               CSR_LOOP_ENABLE: loop_ff      <= csr_data[0];
               CSR_KEY_COUNT:   key_count_ff <= csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      addr_ff      <= addr_in;
      frac_ff      <= frac_in;
      value_ff     <= value_in;
      after_ff     <= after_in;
      hit_valid_ff <= hit_valid_in;
      at_end_ff    <= at_end_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== rtl/ksm_checker.sv =====
// Port-level checker for the keyframe step sampler, bound to the top level.
// Depends on ksm_pkg for port widths and flag positions.
module ksm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [0:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ksm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [ksm_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import ksm_pkg::*;

   // A sample word occupies the block: the request side drops at once.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser[0] == OP_SAMPLE)) |=> !req_tready)
      else $error("request side stayed ready after a sample word");

   // A new result is only produced while the request side is held off.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a sample at work");

   // An empty table answers with a cleared word.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[RSP_USER_VALID]) |->
         ((rsp_tdata == '0) && !rsp_tuser[RSP_USER_END]))
      else $error("invalid result carries data or the end flag");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result word changed while stalled");

endmodule

bind keyframe_step_sampler_top ksm_checker u_ksm_checker (.*);

// ===== bench/tb_keyframe_step_sampler_top.sv =====
// Self-checking bench for keyframe_step_sampler_top: a directed table, then random phases
// of register settings, table fills and samples, all checked against a local predictor.
// Depends on ksm_pkg and the RTL of the sampler only.
module tb_keyframe_step_sampler_top;
   import ksm_pkg::*;

   localparam int NUM_KEYS       = MAX_KEYS_DEFAULT;
   localparam int NUM_PHASES     = 14;
   localparam int BODY_ITEMS     = 24;
   localparam int PRESSURE_PHASE = 5;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 120;
   localparam int STALL_LIMIT    = 3000;

   // Value words of the directed table, chosen to be told apart at a glance.
   localparam logic [VAL_W-1:0] V0 = 32'h0000_0001;
   localparam logic [VAL_W-1:0] V1 = 32'h1234_5678;
   localparam logic [VAL_W-1:0] V2 = 32'h8000_0000;
   localparam logic [VAL_W-1:0] V3 = 32'hFFFF_FFFF;

   typedef struct packed {
      op_type             op;
      logic [INDEX_W-1:0] idx;
      logic [POS_W-1:0]   pos;
      logic [VAL_W-1:0]   val;
      logic [TIME_W-1:0]  t;
   } key_req_type;

   typedef struct packed {
      logic             ok;
      logic [VAL_W-1:0] value;
      logic             at_end;
   } sample_rsp_type;

   typedef struct packed {
      logic           is_reg;
      csr_index_type  reg_idx;
      logic [CSR_W-1:0] reg_data;
      key_req_type    item;
      logic           typed;
      sample_rsp_type want;
   } script_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [0:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_W-1:0]       csr_data;

   // Predictor state: registers and keyframe table as the block should hold them.
   logic [TIME_W-1:0]  start_r;
   logic [TIME_W-1:0]  dur_r;
   logic               loop_r;
   logic [COUNT_W-1:0] count_r;
   logic [POS_W-1:0]   tbl_pos [NUM_KEYS];
   logic [VAL_W-1:0]   tbl_val [NUM_KEYS];
   bit                 known [NUM_KEYS];

   sample_rsp_type pending_samples [$];
   int          errors = 0;
   bit          req_pace = 1'b1;
   bit          rsp_pace = 1'b1;
   bit          hold_output = 1'b0;

   keyframe_step_sampler_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Entries in use: the count register saturates at the table depth.
   function automatic int live_keys();
      return (count_r > NUM_KEYS) ? NUM_KEYS : int'(count_r);
   endfunction

   // Animation fraction in Q1.16; time at or below start counts down from one.
   function automatic logic [POS_W-1:0] anim_fraction(logic [TIME_W-1:0] t);
      logic [63:0] part;
      if (dur_r == '0)
         return FRAC_ONE;
      if (t > start_r) begin
         part = 64'(t - start_r) % 64'(dur_r);
         return POS_W'((part << FRAC_BITS) / 64'(dur_r));
      end
      part = 64'(start_r - t) % 64'(dur_r);
      return FRAC_ONE - POS_W'((part << FRAC_BITS) / 64'(dur_r));
   endfunction

   // Expected answer to a sample word under the current settings and table.
   function automatic sample_rsp_type predict_sample(logic [TIME_W-1:0] t);
      sample_rsp_type   r;
      int               n;
      int               sel;
      logic [TIME_W-1:0] end_t;
      logic [POS_W-1:0] frac;
      r = '0;
      n = live_keys();
      if (n == 0)
         return r;
      r.ok = 1'b1;
      end_t = start_r + dur_r;
      if (!loop_r && t < start_r) begin
         r.value = tbl_val[0];
         r.at_end = 1'b1;
         return r;
      end
      if (!loop_r && t > end_t) begin
         r.value = tbl_val[n-1];
         r.at_end = 1'b1;
         return r;
      end
      frac = anim_fraction(t);
      sel = 0;
      for (int i = 0; i < n; i++) begin
         if (tbl_pos[i] <= frac)
            sel = i;
         else
            break;
      end
      r.value = tbl_val[sel];
      return r;
   endfunction

   function automatic script_row_type reg_row(csr_index_type idx, logic [CSR_W-1:0] data);
      script_row_type row;
      row = '0;
      row.is_reg = 1'b1;
      row.reg_idx = idx;
      row.reg_data = data;
      return row;
   endfunction

   function automatic script_row_type item_row(op_type op, logic [INDEX_W-1:0] idx,
                                               logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                                               logic [TIME_W-1:0] t, logic typed,
                                               sample_rsp_type want);
      script_row_type row;
      row = '0;
      row.item = '{op: op, idx: idx, pos: pos, val: val, t: t};
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] wanted);
      $display("mismatch at %0t: %s got %h, expected %h", $time, field, got, wanted);
      errors++;
   endtask

   // Offer one request word after a drawn gap; update the predictor once it is taken.
   task automatic send_item(key_req_type it, logic typed, sample_rsp_type want);
      logic [REQ_TDATA_W-1:0] word;
      int                     gap;
      gap = req_pace ? $urandom_range(0, 10) : 0;
      word = '0;
      word[REQ_INDEX_LSB +: INDEX_W] = it.idx;
      word[REQ_POS_LSB +: POS_W] = it.pos;
      word[REQ_VAL_LSB +: VAL_W] = it.val;
      word[REQ_TIME_LSB +: TIME_W] = it.t;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= it.op;
      do @(posedge clock); while (!req_tready);
      if (it.op == OP_WRITE) begin
         if (it.idx < live_keys()) begin
            tbl_pos[it.idx] = it.pos;
            tbl_val[it.idx] = it.val;
            known[it.idx] = 1'b1;
         end
      end else begin
         pending_samples.push_back(typed ? want : predict_sample(it.t));
      end
   endtask

   // Register write; valid stays high across a run of writes and is lowered by the caller.
   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_START_TIME:  start_r = data;
         CSR_DURATION:    dur_r = data;
         CSR_LOOP_ENABLE: loop_r = data[0];
         CSR_KEY_COUNT:   count_r = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Wait until every sample has answered and a trailing write has surely finished.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: drawn stalls, one long hold on request, and the field-by-field check.
   initial begin : result_side
      sample_rsp_type want;
      int             gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = rsp_pace ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_samples.size() == 0) begin
            flag_mismatch("unexpected word", rsp_tdata, '0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tuser[RSP_USER_VALID] !== want.ok)
               flag_mismatch("result_valid", 32'(rsp_tuser[RSP_USER_VALID]), 32'(want.ok));
            if (rsp_tdata !== want.value)
               flag_mismatch("sampled_value", rsp_tdata, want.value);
            if (rsp_tuser[RSP_USER_END] !== want.at_end)
               flag_mismatch("at_end", 32'(rsp_tuser[RSP_USER_END]), 32'(want.at_end));
         end
      end
   end

   // Watchdog: ends the run when no channel has moved a word for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      script_row_type    script [$];
      key_req_type       it;
      bit                in_cfg;
      bit                sorted;
      int                n;
      int                pos;
      int                step;
      logic [TIME_W-1:0] sv;
      logic [TIME_W-1:0] dv;
      logic              lv;
      logic [COUNT_W-1:0] cv;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_WRITE;
      csr_valid <= 1'b0;
      csr_index <= CSR_START_TIME;
      csr_data <= '0;
      start_r = '0;
      dur_r = '0;
      loop_r = 1'b0;
      count_r = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         tbl_pos[i] = '0;
         tbl_val[i] = '0;
         known[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table: reset state, ignored writes, clamping, looping and wrap extremes.
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 0, 1'b1, '{1'b0, '0, 1'b0}));
      script.push_back(item_row(OP_WRITE, 0, 0, 32'hA5A5_A5A5, 0, 1'b0, '0));
      script.push_back(reg_row(CSR_KEY_COUNT, 4));
      script.push_back(reg_row(CSR_START_TIME, 1000));
      script.push_back(reg_row(CSR_DURATION, 1000));
      script.push_back(reg_row(CSR_LOOP_ENABLE, 0));
      script.push_back(item_row(OP_WRITE, 0, 16384, V0, 0, 1'b0, '0));
      script.push_back(item_row(OP_WRITE, 1, 32768, V1, 0, 1'b0, '0));
      script.push_back(item_row(OP_WRITE, 2, 49152, V2, 0, 1'b0, '0));
      script.push_back(item_row(OP_WRITE, 3, 65536, V3, 0, 1'b0, '0));
      script.push_back(item_row(OP_WRITE, 4, 0, 0, 0, 1'b0, '0));
      script.push_back(item_row(OP_WRITE, 15, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                1'b0, '0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 999, 1'b1, '{1'b1, V0, 1'b1}));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 2001, 1'b1, '{1'b1, V3, 1'b1}));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 1000, 1'b0, '0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 2000, 1'b0, '0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 1100, 1'b0, '0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 1500, 1'b0, '0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 1750, 1'b0, '0));
      script.push_back(item_row(OP_SAMPLE, 15, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                1'b1, '{1'b1, V3, 1'b1}));
      script.push_back(reg_row(CSR_LOOP_ENABLE, 1));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 0, 1'b0, '0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, '0));
      script.push_back(reg_row(CSR_DURATION, 0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 1234, 1'b0, '0));
      script.push_back(reg_row(CSR_START_TIME, 32'hFFFF_FFFF));
      script.push_back(reg_row(CSR_DURATION, 32'hFFFF_FFFF));
      script.push_back(reg_row(CSR_LOOP_ENABLE, 0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, '0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 0, 1'b1, '{1'b1, V0, 1'b1}));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, '0));
      script.push_back(reg_row(CSR_KEY_COUNT, 0));
      script.push_back(item_row(OP_SAMPLE, 0, 0, 0, 5, 1'b1, '{1'b0, '0, 1'b0}));

      in_cfg = 1'b0;
      foreach (script[i]) begin
         if (script[i].is_reg) begin
            if (!in_cfg) begin
               settle();
               in_cfg = 1'b1;
            end
            write_reg(script[i].reg_idx, script[i].reg_data);
         end else begin
            if (in_cfg) begin
               csr_valid <= 1'b0;
               in_cfg = 1'b0;
            end
            send_item(script[i].item, script[i].typed, script[i].want);
         end
      end

      // Random phases: new settings, a table fill, then a mix of samples and writes.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         case ((ph < 5) ? ph : $urandom_range(0, 4))
            0:       sv = '0;
            1:       sv = 32'hFFFF_FFFF;
            2:       sv = $urandom;
            3:       sv = $urandom_range(0, 1000);
            default: sv = 32'hFFFF_FFFF - $urandom_range(0, 500);
         endcase
         case ((ph < 6) ? ph : $urandom_range(0, 5))
            0:       dv = '0;
            1:       dv = 1;
            2:       dv = 32'hFFFF_FFFF;
            3:       dv = $urandom_range(2, 300);
            4:       dv = $urandom;
            default: dv = $urandom_range(1000, 100000);
         endcase
         lv = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
         case (ph)
            0:       cv = 5'd16;
            1:       cv = 5'd1;
            2:       cv = 5'd31;
            3:       cv = 5'd0;
            default: cv = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(17, 31))
                                                      : COUNT_W'($urandom_range(1, 16));
         endcase
         // Unused upper bits of the narrow registers carry random junk.
         write_reg(CSR_START_TIME, sv);
         write_reg(CSR_DURATION, dv);
         write_reg(CSR_LOOP_ENABLE, ($urandom & ~32'h1) | lv);
         write_reg(CSR_KEY_COUNT, ($urandom & ~32'h1F) | cv);
         csr_valid <= 1'b0;

         req_pace = ($urandom_range(0, 2) != 0);
         rsp_pace = ($urandom_range(0, 2) != 0);
         if (ph == PRESSURE_PHASE) begin
            hold_output = 1'b1;
            req_pace = 1'b0;
         end

         // Fill the entries in use; some already written entries keep their contents.
         n = live_keys();
         sorted = ($urandom_range(0, 3) != 0);
         step = 131072 / ((n > 0) ? n : 1);
         pos = 0;
         for (int k = 0; k < n; k++) begin
            if (sorted) begin
               pos = pos + $urandom_range(0, step);
               if (pos > 65536)
                  pos = 65536;
            end else begin
               pos = $urandom_range(0, 131071);
            end
            if (!known[k] || $urandom_range(0, 2) != 0) begin
               it = '{op: OP_WRITE, idx: INDEX_W'(k), pos: POS_W'(pos), val: $urandom,
                      t: $urandom};
               send_item(it, 1'b0, '0);
            end
         end

         repeat (BODY_ITEMS) begin
            it.idx = INDEX_W'($urandom_range(0, 15));
            it.pos = POS_W'($urandom_range(0, 131071));
            it.val = $urandom;
            it.t = $urandom;
            if ($urandom_range(0, 3) == 0) begin
               it.op = OP_WRITE;
            end else begin
               it.op = OP_SAMPLE;
               case ($urandom_range(0, 7))
                  0, 1, 2: it.t = start_r + $urandom_range(0, dur_r);
                  3:       it.t = start_r - $urandom_range(1, 1000);
                  4:       it.t = start_r + dur_r + $urandom_range(1, 1000);
                  5:       it.t = $urandom_range(0, 1) ? start_r : start_r + dur_r;
                  6:       it.t = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
                  default: ;
               endcase
            end
            send_item(it, 1'b0, '0);
         end
      end

      settle();
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
